// ===== rtl/mtq_pkg.sv =====
// shared types and constants for the missing energy quantizer
// no dependencies

package mtq_pkg;

  localparam int VALUE_BITS_DEF  = 6;
  localparam int RANGE_COUNT_DEF = 4;

  localparam int FIELD_W = 15;
  localparam int MET_W   = 7;
  localparam int RANGE_W = 2;
  localparam int SQ_W    = 25;
  localparam int RAD_W   = 14;

  localparam logic [MET_W-1:0]   MET_MAX      = '1;
  localparam logic [RANGE_W-1:0] RANGE_OVF    = '1;
  localparam logic [SQ_W-1:0]    MET_SQ_OVF   = 25'd16777216;
  localparam logic [SQ_W-1:0]    MET_SQ_MAX   = '1;
  localparam int                 ROOT_SAT_SQ  = 16129;

  typedef struct packed {
    logic [MET_W-1:0] root;
    logic [RAD_W-1:0] root_sq;
    logic [RAD_W-1:0] radicand;
    logic             sat;
  } root_t;

  typedef struct packed {
    logic [SQ_W-1:0]    met_squared;
    logic [RANGE_W-1:0] range_index;
    logic               overflow;
  } side_t;

endpackage

// ===== rtl/mtq_range.sv =====
// first stage: magnitudes, range choice and overflow detection
// depends on mtq_pkg

module mtq_range #(
  parameter int VALUE_BITS  = mtq_pkg::VALUE_BITS_DEF,
  parameter int RANGE_COUNT = mtq_pkg::RANGE_COUNT_DEF,
  parameter int RW          = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mtq_pkg::FIELD_W-1:0]  ex,
  input  logic [mtq_pkg::FIELD_W-1:0]  ey,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mtq_pkg::FIELD_W-1:0]  out_ax,
  output logic [mtq_pkg::FIELD_W-1:0]  out_ay,
  output logic [RW-1:0]                out_range,
  output logic                         out_ovf
);
  import mtq_pkg::*;

  localparam int OVF_EXP = VALUE_BITS + RANGE_COUNT - 1;

  logic               vld;
  logic [FIELD_W-1:0] ax, ay;
  logic [RW-1:0]      r;
  logic               ovf;

  logic [FIELD_W-1:0] ax_next, ay_next, mx;
  logic [RW-1:0]      r_next;
  logic               ovf_next;

  always_comb begin
    ax_next = ex[FIELD_W-1] ? (~ex + FIELD_W'(1)) : ex;
    ay_next = ey[FIELD_W-1] ? (~ey + FIELD_W'(1)) : ey;
    mx      = (ax_next > ay_next) ? ax_next : ay_next;
    ovf_next = (mx >> OVF_EXP) != '0;
    r_next   = '0;
    for (int k = 0; k < RANGE_COUNT - 1; k++) begin
      if ((mx >> (VALUE_BITS + k)) != '0) begin
        r_next = RW'(k + 1);
      end
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_ax    = ax;
  assign out_ay    = ay;
  assign out_range = r;
  assign out_ovf   = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ax  <= ax_next;
      ay  <= ay_next;
      r   <= r_next;
      ovf <= ovf_next;
    end
  end

endmodule

// ===== rtl/mtq_square.sv =====
// second and third stages: mask and square, then sum, rescale and saturate
// depends on mtq_pkg

module mtq_square #(
  parameter int VALUE_BITS  = mtq_pkg::VALUE_BITS_DEF,
  parameter int RANGE_COUNT = mtq_pkg::RANGE_COUNT_DEF,
  parameter int RW          = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mtq_pkg::FIELD_W-1:0]  in_ax,
  input  logic [mtq_pkg::FIELD_W-1:0]  in_ay,
  input  logic [RW-1:0]                in_range,
  input  logic                         in_ovf,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mtq_pkg::root_t               out_root,
  output mtq_pkg::side_t               out_side
);
  import mtq_pkg::*;

  localparam int PW  = 2 * VALUE_BITS;
  localparam int QW  = PW + 1;
  localparam int SQW = QW + 2 * (RANGE_COUNT - 1);

  // square stage
  logic          vld_sq;
  logic [PW-1:0] sqx, sqy;
  logic [RW-1:0] r_sq;
  logic          ovf_sq;

  logic [VALUE_BITS-1:0] sx, sy;
  logic                  ready_sq;

  // sum stage
  logic  vld_sum;
  root_t sum_root, sum_root_next;
  side_t sum_side, sum_side_next;

  logic [QW-1:0]  q;
  logic [SQW-1:0] wide;
  logic           ready_sum;

  assign sx = VALUE_BITS'(in_ax >> in_range);
  assign sy = VALUE_BITS'(in_ay >> in_range);

  assign ready_sum = !vld_sum || out_ready;
  assign ready_sq  = !vld_sq || ready_sum;
  assign in_ready  = ready_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sq <= 1'b0;
    end else if (ready_sq) begin
      vld_sq <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_sq && in_valid) begin
      sqx    <= PW'(sx) * PW'(sx);
      sqy    <= PW'(sy) * PW'(sy);
      r_sq   <= in_range;
      ovf_sq <= in_ovf;
    end
  end

  always_comb begin
    q    = QW'(sqx) + QW'(sqy);
    wide = SQW'(q) << {r_sq, 1'b0};
    sum_root_next.root     = '0;
    sum_root_next.root_sq  = '0;
    sum_root_next.radicand = RAD_W'(q);
    sum_root_next.sat      = 32'(q) > ROOT_SAT_SQ;
    sum_side_next.overflow = ovf_sq;
    if (ovf_sq) begin
      sum_side_next.met_squared = MET_SQ_OVF;
      sum_side_next.range_index = RANGE_OVF;
    end else begin
      sum_side_next.met_squared = ((wide >> SQ_W) != '0) ? MET_SQ_MAX : SQ_W'(wide);
      sum_side_next.range_index = RANGE_W'(r_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sum <= 1'b0;
    end else if (ready_sum) begin
      vld_sum <= vld_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_sum && vld_sq) begin
      sum_root <= sum_root_next;
      sum_side <= sum_side_next;
    end
  end

  assign out_valid = vld_sum;
  assign out_root  = sum_root;
  assign out_side  = sum_side;

endmodule

// ===== rtl/mtq_root_stage.sv =====
// one pipeline stage of the square root: resolves a few root bits, msb first
// depends on mtq_pkg

module mtq_root_stage #(
  parameter int TOP_BIT = 6,
  parameter int STEPS   = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mtq_pkg::root_t in_root,
  input  mtq_pkg::side_t in_side,
  output logic           out_valid,
  input  logic           out_ready,
  output mtq_pkg::root_t out_root,
  output mtq_pkg::side_t out_side
);
  import mtq_pkg::*;

  logic  vld;
  root_t stage_root, stage_root_next;
  side_t stage_side;

  always_comb begin
    int               b;
    logic [RAD_W-1:0] t2;
    stage_root_next = in_root;
    for (int i = 0; i < STEPS; i++) begin
      b  = TOP_BIT - i;
      t2 = stage_root_next.root_sq + (RAD_W'(stage_root_next.root) << (b + 1))
           + (RAD_W'(1) << (2 * b));
      if (t2 <= stage_root_next.radicand) begin
        stage_root_next.root    = stage_root_next.root | (MET_W'(1) << b);
        stage_root_next.root_sq = t2;
      end
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_root  = stage_root;
  assign out_side  = stage_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_root <= stage_root_next;
      stage_side <= in_side;
    end
  end

`ifndef ASSERT_OFF
  a_root_sq_exact: assert property (@(posedge clk) disable iff (rst)
    vld |-> stage_root.root_sq ==
            RAD_W'(RAD_W'(stage_root.root) * RAD_W'(stage_root.root)))
    else $error("partial root square out of step with partial root");

  a_root_below: assert property (@(posedge clk) disable iff (rst)
    vld && !stage_root.sat |-> stage_root.root_sq <= stage_root.radicand)
    else $error("partial root square above radicand");
`endif

endmodule

// ===== rtl/missing_et_quantizer.sv =====
// top level of the missing energy quantizer: range stage, square stages,
// root pipeline and output register; depends on mtq_pkg and the mtq_ modules
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   input    | item_valid, item_stall | ex, ey
//   output   | met_valid, met_stall   | met_value, range_index, met_squared, overflow
//
// one item per cycle sustained while met_stall is low; an item passes through the range,
// square, sum, three root stages and output register
// synchronous reset clears all stage valid bits, payload registers are not reset
// a stall on the output holds each full stage that has no empty stage after it; the rest keep filling

module missing_et_quantizer #(
  parameter int VALUE_BITS  = mtq_pkg::VALUE_BITS_DEF,
  parameter int RANGE_COUNT = mtq_pkg::RANGE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [mtq_pkg::FIELD_W-1:0]  ex,
  input  logic [mtq_pkg::FIELD_W-1:0]  ey,
  output logic                         met_valid,
  input  logic                         met_stall,
  output logic [mtq_pkg::MET_W-1:0]    met_value,
  output logic [mtq_pkg::RANGE_W-1:0]  range_index,
  output logic [mtq_pkg::SQ_W-1:0]     met_squared,
  output logic                         overflow
);
  import mtq_pkg::*;

  localparam int RW = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;

  logic               rng_ready, rng_valid;
  logic [FIELD_W-1:0] rng_ax, rng_ay;
  logic [RW-1:0]      rng_range;
  logic               rng_ovf;

  logic  sq_ready, sq_valid;
  root_t sq_root;
  side_t sq_side;

  logic  r0_ready, r0_valid;
  root_t r0_root;
  side_t r0_side;

  logic  r1_ready, r1_valid;
  root_t r1_root;
  side_t r1_side;

  logic  out_ready_r2;

  logic  r2_valid;
  root_t r2_root;
  side_t r2_side;

  logic             out_ready;
  logic             vld;
  logic [MET_W-1:0] value, value_next, ceil_root;
  side_t            side;

  mtq_range #(
    .VALUE_BITS  (VALUE_BITS),
    .RANGE_COUNT (RANGE_COUNT),
    .RW          (RW)
  ) u_range (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (rng_ready),
    .ex        (ex),
    .ey        (ey),
    .out_valid (rng_valid),
    .out_ready (sq_ready),
    .out_ax    (rng_ax),
    .out_ay    (rng_ay),
    .out_range (rng_range),
    .out_ovf   (rng_ovf)
  );

  mtq_square #(
    .VALUE_BITS  (VALUE_BITS),
    .RANGE_COUNT (RANGE_COUNT),
    .RW          (RW)
  ) u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rng_valid),
    .in_ready  (sq_ready),
    .in_ax     (rng_ax),
    .in_ay     (rng_ay),
    .in_range  (rng_range),
    .in_ovf    (rng_ovf),
    .out_valid (sq_valid),
    .out_ready (r0_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  mtq_root_stage #(.TOP_BIT(6), .STEPS(3)) u_root_hi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (r0_ready),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (r0_valid),
    .out_ready (r1_ready),
    .out_root  (r0_root),
    .out_side  (r0_side)
  );

  mtq_root_stage #(.TOP_BIT(3), .STEPS(2)) u_root_mid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r0_valid),
    .in_ready  (r1_ready),
    .in_root   (r0_root),
    .in_side   (r0_side),
    .out_valid (r1_valid),
    .out_ready (out_ready_r2),
    .out_root  (r1_root),
    .out_side  (r1_side)
  );

  mtq_root_stage #(.TOP_BIT(1), .STEPS(2)) u_root_lo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r1_valid),
    .in_ready  (out_ready_r2),
    .in_root   (r1_root),
    .in_side   (r1_side),
    .out_valid (r2_valid),
    .out_ready (out_ready),
    .out_root  (r2_root),
    .out_side  (r2_side)
  );

  // round the floor root up when the radicand is not a perfect square
  always_comb begin
    ceil_root = (r2_root.root_sq < r2_root.radicand) ? (r2_root.root + MET_W'(1))
                                                     : r2_root.root;
    value_next = (r2_side.overflow || r2_root.sat) ? MET_MAX : ceil_root;
  end

  assign out_ready  = !vld || !met_stall;
  assign item_stall = !rng_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (out_ready) begin
      vld <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && r2_valid) begin
      value <= value_next;
      side  <= r2_side;
    end
  end

  assign met_valid   = vld;
  assign met_value   = value;
  assign range_index = side.range_index;
  assign met_squared = side.met_squared;
  assign overflow    = side.overflow;

`ifndef ASSERT_OFF
  a_ovf_marker: assert property (@(posedge clk) disable iff (rst)
    met_valid && overflow |-> met_value == MET_MAX && range_index == RANGE_OVF
                              && met_squared == MET_SQ_OVF)
    else $error("overflow item without marker results");

  a_zero_agree: assert property (@(posedge clk) disable iff (rst)
    met_valid && !overflow |-> (met_value == '0) == (met_squared == '0))
    else $error("root and squared sum disagree on zero");
`endif

endmodule
